// ===== rtl/core/json_string_unescape_utf8_assert.svh =====
// Assertion macros shared by the string unescaper RTL.
// Include in modules that carry concurrent checks; no other dependencies.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define JSU_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define JSU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/jsu_pkg.sv =====
// Shared types, constants and UTF-8 helpers for the string unescaper.
// Used by jsu_front, jsu_cmd_fifo, jsu_back and the top level; no dependencies.
`timescale 1ns / 1ps

package jsu_pkg;

  // default depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // code point width, enough for a joined surrogate pair
  localparam int unsigned CP_W = 21;

  // UTF-8 length thresholds
  localparam logic [CP_W-1:0] CP_LIM1 = 21'h00080;
  localparam logic [CP_W-1:0] CP_LIM2 = 21'h00800;
  localparam logic [CP_W-1:0] CP_LIM3 = 21'h10000;

  // UTF-8 lead and continuation prefixes
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

  // what one output slot of a command carries
  typedef enum logic [1:0] {
    SLOT_NONE = 2'd0,
    SLOT_RAW  = 2'd1,
    SLOT_UTF8 = 2'd2
  } slot_kind_t;

  // one command: up to two emitted values, then optionally end of string
  typedef struct packed {
    slot_kind_t       s0_kind;
    logic [CP_W-1:0]  s0_val;
    slot_kind_t       s1_kind;
    logic [CP_W-1:0]  s1_val;
    logic             fin;
  } cmd_t;

  // number of bytes a slot expands to (1..4)
  function automatic logic [2:0] slot_len(input slot_kind_t kind, input logic [CP_W-1:0] val);
    logic [2:0] len;
    len = 3'd1;
    if (kind == SLOT_UTF8) begin
      if (val < CP_LIM1)      len = 3'd1;
      else if (val < CP_LIM2) len = 3'd2;
      else if (val < CP_LIM3) len = 3'd3;
      else                    len = 3'd4;
    end
    return len;
  endfunction

  // byte number idx of a slot's expansion
  function automatic logic [7:0] slot_byte(input slot_kind_t kind, input logic [CP_W-1:0] val,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = val[7:0];
    if (kind == SLOT_UTF8) begin
      unique case (slot_len(kind, val))
        3'd2: begin
          b = (idx == 2'd0) ? (LEAD2 | {3'b000, val[10:6]}) : (CONT | {2'b00, val[5:0]});
        end
        3'd3: begin
          unique case (idx)
            2'd0:    b = LEAD3 | {4'b0000, val[15:12]};
            2'd1:    b = CONT | {2'b00, val[11:6]};
            default: b = CONT | {2'b00, val[5:0]};
          endcase
        end
        3'd4: begin
          unique case (idx)
            2'd0:    b = LEAD4 | {5'b00000, val[20:18]};
            2'd1:    b = CONT | {2'b00, val[17:12]};
            2'd2:    b = CONT | {2'b00, val[11:6]};
            default: b = CONT | {2'b00, val[5:0]};
          endcase
        end
        default: b = val[7:0];
      endcase
    end
    return b;
  endfunction

endpackage

// ===== rtl/core/jsu_front.sv =====
// Front end: parses input bytes and emits one command word per byte that has output.
// Depends on jsu_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "json_string_unescape_utf8_assert.svh"

module jsu_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  output logic             cmd_valid,
  output jsu_pkg::cmd_t    cmd
);

  // characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;

  typedef enum logic [5:0] {
    M_PLAIN    = 6'b000001,
    M_ESC      = 6'b000010,
    M_HEX      = 6'b000100,
    M_HIGH     = 6'b001000,
    M_HIGH_BSL = 6'b010000,
    M_LOHEX    = 6'b100000
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] held_r, held_nxt;

  logic [15:0] acc_sh;
  logic        is_nul;
  logic        is_term;

  // hex digit value, zero for anything else
  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [3:0] v;
    v = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) v = b[3:0];
    else if (b >= 8'h61 && b <= 8'h66) v = b[3:0] + 4'd9;
    else if (b >= 8'h41 && b <= 8'h46) v = b[3:0] + 4'd9;
    return v;
  endfunction

  // simple escape letters map to control codes, others stand for themselves
  function automatic logic [7:0] esc_map(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (b == CH_N)      c = 8'h0A;
    else if (b == CH_T) c = 8'h09;
    else if (b == CH_R) c = 8'h0D;
    else if (b == CH_B) c = 8'h08;
    else if (b == CH_F) c = 8'h0C;
    return c;
  endfunction

  function automatic logic is_high(input logic [15:0] v);
    return v[15:10] == 6'b110110;
  endfunction

  function automatic logic is_low(input logic [15:0] v);
    return v[15:10] == 6'b110111;
  endfunction

  assign acc_sh  = {acc_r[11:0], hex_val(in_byte)};
  assign is_nul  = (in_byte == CH_NUL);
  assign is_term = is_nul || (in_byte == CH_QUOTE);

  // parser next state and command
  always_comb begin
    mode_nxt    = mode_r;
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    held_nxt    = held_r;
    cmd.s0_kind = jsu_pkg::SLOT_NONE;
    cmd.s0_val  = '0;
    cmd.s1_kind = jsu_pkg::SLOT_NONE;
    cmd.s1_val  = '0;
    cmd.fin     = 1'b0;

    unique case (mode_r)
      M_ESC: begin
        mode_nxt = M_PLAIN;
        if (is_nul) begin
          cmd.fin = 1'b1;
        end else if (in_byte == CH_U) begin
          mode_nxt = M_HEX;
          cnt_nxt  = 2'd0;
          acc_nxt  = 16'h0000;
        end else begin
          cmd.s0_kind = jsu_pkg::SLOT_RAW;
          cmd.s0_val  = {13'd0, esc_map(in_byte)};
        end
      end

      M_HEX: begin
        if (is_nul) begin
          cmd.s0_kind = jsu_pkg::SLOT_UTF8;
          cmd.s0_val  = {5'd0, acc_r};
          cmd.fin     = 1'b1;
        end else if (cnt_r != 2'd3) begin
          acc_nxt = acc_sh;
          cnt_nxt = cnt_r + 2'd1;
        end else begin
          acc_nxt = 16'h0000;
          cnt_nxt = 2'd0;
          if (is_high(acc_sh)) begin
            held_nxt = acc_sh;
            mode_nxt = M_HIGH;
          end else begin
            cmd.s0_kind = jsu_pkg::SLOT_UTF8;
            cmd.s0_val  = {5'd0, acc_sh};
            mode_nxt    = M_PLAIN;
          end
        end
      end

      M_HIGH: begin
        if (in_byte == CH_BSL) begin
          mode_nxt = M_HIGH_BSL;
        end else begin
          // unpaired high surrogate, then the byte as plain text or end of string
          cmd.s0_kind = jsu_pkg::SLOT_UTF8;
          cmd.s0_val  = {5'd0, held_r};
          held_nxt    = 16'h0000;
          mode_nxt    = M_PLAIN;
          if (is_term) begin
            cmd.fin = 1'b1;
          end else begin
            cmd.s1_kind = jsu_pkg::SLOT_RAW;
            cmd.s1_val  = {13'd0, in_byte};
          end
        end
      end

      M_HIGH_BSL: begin
        if (in_byte == CH_U) begin
          mode_nxt = M_LOHEX;
          cnt_nxt  = 2'd0;
          acc_nxt  = 16'h0000;
        end else begin
          // unpaired high surrogate, then an ordinary escape or end of string
          cmd.s0_kind = jsu_pkg::SLOT_UTF8;
          cmd.s0_val  = {5'd0, held_r};
          held_nxt    = 16'h0000;
          mode_nxt    = M_PLAIN;
          if (is_nul) begin
            cmd.fin = 1'b1;
          end else begin
            cmd.s1_kind = jsu_pkg::SLOT_RAW;
            cmd.s1_val  = {13'd0, esc_map(in_byte)};
          end
        end
      end

      M_LOHEX: begin
        if (is_nul) begin
          cmd.s0_kind = jsu_pkg::SLOT_UTF8;
          cmd.s0_val  = {5'd0, held_r};
          cmd.s1_kind = jsu_pkg::SLOT_UTF8;
          cmd.s1_val  = {5'd0, acc_r};
          cmd.fin     = 1'b1;
        end else if (cnt_r != 2'd3) begin
          acc_nxt = acc_sh;
          cnt_nxt = cnt_r + 2'd1;
        end else begin
          acc_nxt = 16'h0000;
          cnt_nxt = 2'd0;
          if (is_low(acc_sh)) begin
            // surrogate pair joins into one supplementary code point
            cmd.s0_kind = jsu_pkg::SLOT_UTF8;
            cmd.s0_val  = jsu_pkg::CP_LIM3 + {1'b0, held_r[9:0], acc_sh[9:0]};
            held_nxt    = 16'h0000;
            mode_nxt    = M_PLAIN;
          end else begin
            cmd.s0_kind = jsu_pkg::SLOT_UTF8;
            cmd.s0_val  = {5'd0, held_r};
            if (is_high(acc_sh)) begin
              held_nxt = acc_sh;
              mode_nxt = M_HIGH;
            end else begin
              held_nxt    = 16'h0000;
              cmd.s1_kind = jsu_pkg::SLOT_UTF8;
              cmd.s1_val  = {5'd0, acc_sh};
              mode_nxt    = M_PLAIN;
            end
          end
        end
      end

      default: begin
        mode_nxt = M_PLAIN;
        if (is_term) begin
          cmd.fin = 1'b1;
        end else if (in_byte == CH_BSL) begin
          mode_nxt = M_ESC;
        end else begin
          cmd.s0_kind = jsu_pkg::SLOT_RAW;
          cmd.s0_val  = {13'd0, in_byte};
        end
      end
    endcase

    // end of string clears all parser state
    if (cmd.fin) begin
      mode_nxt = M_PLAIN;
      cnt_nxt  = 2'd0;
      acc_nxt  = 16'h0000;
      held_nxt = 16'h0000;
    end
  end

  assign cmd_valid = accept && (cmd.fin || (cmd.s0_kind != jsu_pkg::SLOT_NONE) ||
                                (cmd.s1_kind != jsu_pkg::SLOT_NONE));

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_PLAIN;
      cnt_r  <= 2'd0;
      acc_r  <= 16'h0000;
      held_r <= 16'h0000;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
    end
  end

  // a held value is always a high surrogate, and is cleared otherwise
  `JSU_ASSERT_IMPL(a_held_is_high, clk, rst_n,
    (mode_r == M_HIGH) || (mode_r == M_HIGH_BSL) || (mode_r == M_LOHEX),
    is_high(held_r), "held value is not a high surrogate")
  `JSU_ASSERT_IMPL(a_held_clear, clk, rst_n,
    (mode_r == M_PLAIN) || (mode_r == M_ESC) || (mode_r == M_HEX),
    held_r == 16'h0000, "held value left over outside surrogate modes")

endmodule

// ===== rtl/core/jsu_cmd_fifo.sv =====
// Short command queue between parser front end and byte emitter.
// Depends on jsu_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "json_string_unescape_utf8_assert.svh"

module jsu_cmd_fifo #(
  parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  jsu_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output jsu_pkg::cmd_t rd_data,
  output logic          empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  jsu_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // pointers meet only when the queue is empty or full
  `JSU_ASSERT_IMPL(a_ptr_meet, clk, rst_n, empty || full, wr_ptr_r == rd_ptr_r,
    "queue pointers disagree with fill count")
  `JSU_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_r <= CNT_W'(DEPTH),
    "queue fill count beyond depth")

endmodule

// ===== rtl/core/jsu_back.sv =====
// Back end: expands queued command words into UTF-8 result words, one a cycle while the output is popped or empty.
// Depends on jsu_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "json_string_unescape_utf8_assert.svh"

module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  jsu_pkg::cmd_t head,
  output logic          head_done,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic          out_byte_valid,
  output logic          out_string_end,
  output logic          out_last
);

  // which part of the command is being emitted
  typedef enum logic [2:0] {
    PH_S0  = 3'b001,
    PH_S1  = 3'b010,
    PH_END = 3'b100
  } phase_t;

  phase_t     ph_r, ph_nxt;
  logic [1:0] idx_r, idx_nxt;

  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       bv_r, end_r, last_r;

  logic       has_s0, has_s1;
  phase_t     cur_ph;
  logic [2:0] cur_len;
  logic [7:0] cur_byte;
  logic       more_bytes;
  logic       next_s1, next_end;
  logic       is_last;
  logic       advance;
  logic       popped;

  assign has_s0 = (head.s0_kind != jsu_pkg::SLOT_NONE);
  assign has_s1 = (head.s1_kind != jsu_pkg::SLOT_NONE);

  // current phase: first present part at or after the phase register
  always_comb begin
    if (ph_r == PH_S0 && has_s0) begin
      cur_ph = PH_S0;
    end else if ((ph_r == PH_S0 || ph_r == PH_S1) && has_s1) begin
      cur_ph = PH_S1;
    end else begin
      cur_ph = PH_END;
    end
  end

  // current byte and what follows it
  always_comb begin
    unique case (cur_ph)
      PH_S0: begin
        cur_len  = jsu_pkg::slot_len(head.s0_kind, head.s0_val);
        cur_byte = jsu_pkg::slot_byte(head.s0_kind, head.s0_val, idx_r);
        next_s1  = has_s1;
        next_end = !has_s1 && head.fin;
      end
      PH_S1: begin
        cur_len  = jsu_pkg::slot_len(head.s1_kind, head.s1_val);
        cur_byte = jsu_pkg::slot_byte(head.s1_kind, head.s1_val, idx_r);
        next_s1  = 1'b0;
        next_end = head.fin;
      end
      default: begin
        cur_len  = 3'd1;
        cur_byte = 8'h00;
        next_s1  = 1'b0;
        next_end = 1'b0;
      end
    endcase
  end

  assign more_bytes = ({1'b0, idx_r} + 3'd1) < cur_len;
  assign is_last    = !more_bytes && !next_s1 && !next_end;
  assign popped     = pop && out_valid_r;
  assign advance    = head_valid && (!out_valid_r || popped);
  assign head_done  = advance && is_last;

  // position for the following cycle
  always_comb begin
    ph_nxt  = ph_r;
    idx_nxt = idx_r;
    if (advance) begin
      priority if (is_last) begin
        ph_nxt  = PH_S0;
        idx_nxt = 2'd0;
      end else if (more_bytes) begin
        ph_nxt  = cur_ph;
        idx_nxt = idx_r + 2'd1;
      end else if (next_s1) begin
        ph_nxt  = PH_S1;
        idx_nxt = 2'd0;
      end else begin
        ph_nxt  = PH_END;
        idx_nxt = 2'd0;
      end
    end
  end

  // position registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_S0;
      idx_r <= 2'd0;
    end else begin
      ph_r  <= ph_nxt;
      idx_r <= idx_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (popped) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r <= cur_byte;
      bv_r   <= (cur_ph != PH_END);
      end_r  <= (cur_ph == PH_END);
      last_r <= is_last;
    end
  end

  assign empty          = !out_valid_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bv_r;
  assign out_string_end = end_r;
  assign out_last       = last_r;

  // the end word carries no byte and closes its input byte
  `JSU_ASSERT_IMPL(a_end_shape, clk, rst_n, out_valid_r && end_r,
    !bv_r && (byte_r == 8'h00) && last_r, "malformed end-of-string word")
  // a waiting command fills an empty output register in the next cycle
  `JSU_ASSERT_NEXT(a_fill, clk, rst_n, head_valid && !out_valid_r, out_valid_r,
    "output register not filled from a waiting command")

endmodule

// ===== rtl/core/json_string_unescape_utf8.sv =====
// JSON string body unescaper to UTF-8. Each accepted byte's command is written to the
// command queue, then each result is loaded into the output register for the ports.
// It takes one input byte a cycle while the queue is not full; the byte emitter gives one
// result a cycle while its output is popped or empty, and the command queue absorbs bursts.
// Reset (rst_n low, synchronous): parser back to plain text, queue and output emptied.
// Uses jsu_pkg, jsu_front, jsu_cmd_fifo and jsu_back.
`timescale 1ns / 1ps

module json_string_unescape_utf8 #(
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_string_end,
  output logic       out_last
);

  logic          accept;
  logic          cmd_valid;
  jsu_pkg::cmd_t cmd;
  logic          q_empty;
  jsu_pkg::cmd_t q_head;
  logic          q_done;

  assign accept = push && !full;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  jsu_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .full    (full),
    .rd_en   (q_done),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (!q_empty),
    .head           (q_head),
    .head_done      (q_done),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_string_end (out_string_end),
    .out_last       (out_last)
  );

endmodule
